// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the converter RTL.
// Uses the clk and rst_n names of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b on the same edge
`define ASSERT_IMPL(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ((a) |-> (b))) \
        else $error("assertion failed");

// condition never true
`define ASSERT_NEVER(label, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(c)) \
        else $error("assertion failed");

`endif

// ===== hdl/rgbhsv_pkg.sv =====
// Package for the RGB to HSV converter: transaction types and defaults.
// No dependencies.
package rgbhsv_pkg;
    localparam int HUE_FRAC_BITS_DEF = 6;
    localparam int SAT_FRAC_BITS_DEF = 15;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [14:0] hue;
        logic [15:0] saturation;
        logic [7:0]  brightness;
    } hsv_t;
endpackage

// ===== hdl/rgbhsv_prep.sv =====
// Input stage: max/min, hue and saturation dividends and divisors.
// Depends on rgbhsv_pkg.
module rgbhsv_prep
    import rgbhsv_pkg::*;
#(
    parameter int HF = HUE_FRAC_BITS_DEF,
    parameter int SF = SAT_FRAC_BITS_DEF,
    parameter int NW = 26
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  pixel_t        pixel,
    output logic          valid,
    output logic [7:0]    val,
    output logic [NW-1:0] hn,
    output logic [7:0]    hd,
    output logic [NW-1:0] sn,
    output logic [7:0]    sd
);
    logic [7:0] hi, lo, span;
    logic [8:0] base;
    logic signed [18:0] diff, num_s, num_w;
    logic [16:0] base_span;
    logic [NW-1:0] hn_next, sn_next;
    logic [7:0] hd_next, sd_next;
    logic valid_reg;
    logic [7:0] val_reg, hd_reg, sd_reg;
    logic [NW-1:0] hn_reg, sn_reg;

    always_comb
    begin
        hi = (pixel.red > pixel.green) ? pixel.red : pixel.green;
        lo = (pixel.red < pixel.green) ? pixel.red : pixel.green;
        if (pixel.blue > hi)
        begin
            hi = pixel.blue;
        end
        if (pixel.blue < lo)
        begin
            lo = pixel.blue;
        end
        span = hi - lo;
        if (pixel.red >= hi)
        begin
            base = 9'd0;
            diff = $signed({11'b0, pixel.green}) - $signed({11'b0, pixel.blue});
        end
        else if (pixel.green >= hi)
        begin
            base = 9'd120;
            diff = $signed({11'b0, pixel.blue}) - $signed({11'b0, pixel.red});
        end
        else
        begin
            base = 9'd240;
            diff = $signed({11'b0, pixel.red}) - $signed({11'b0, pixel.green});
        end
        base_span = 17'(base) * 17'(span);
        num_s = $signed({2'b0, base_span}) + 19'sd60 * diff;
        num_w = num_s;
        if (num_s < 0)
        begin
            num_w = num_s + $signed({2'b0, 17'(17'd360 * 17'(span))});
        end
        hn_next = (NW'(num_w[16:0]) << HF) + NW'(span >> 1);
        sn_next = (NW'(span) << SF) + NW'(hi >> 1);
        hd_next = (span == 8'd0) ? 8'd1 : span;
        sd_next = (hi == 8'd0) ? 8'd1 : hi;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= hi;
        hn_reg  <= hn_next;
        sn_reg  <= sn_next;
        hd_reg  <= hd_next;
        sd_reg  <= sd_next;
    end

    assign valid = valid_reg;
    assign val   = val_reg;
    assign hn    = hn_reg;
    assign sn    = sn_reg;
    assign hd    = hd_reg;
    assign sd    = sd_reg;
endmodule

// ===== hdl/rgbhsv_cell.sv =====
// Divider cell: settles one quotient bit of the hue and saturation divisions.
// Depends on rgbhsv_pkg.
module rgbhsv_cell
    import rgbhsv_pkg::*;
#(
    parameter int NW = 26,
    parameter int QW = 16,
    parameter int K  = 0
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          valid_i,
    input  logic [7:0]    val_i,
    input  logic [NW-1:0] hn_i,
    input  logic [7:0]    hd_i,
    input  logic [NW-1:0] sn_i,
    input  logic [7:0]    sd_i,
    input  logic [QW-1:0] hq_i,
    input  logic [QW-1:0] sq_i,
    output logic          valid_o,
    output logic [7:0]    val_o,
    output logic [NW-1:0] hn_o,
    output logic [7:0]    hd_o,
    output logic [NW-1:0] sn_o,
    output logic [7:0]    sd_o,
    output logic [QW-1:0] hq_o,
    output logic [QW-1:0] sq_o
);
    localparam int CW = NW + QW + 8;

    logic [CW-1:0] hsh, ssh;
    logic [NW-1:0] hn_next, sn_next;
    logic [QW-1:0] hq_next, sq_next;
    logic valid_reg;
    logic [7:0] val_reg, hd_reg, sd_reg;
    logic [NW-1:0] hn_reg, sn_reg;
    logic [QW-1:0] hq_reg, sq_reg;

    always_comb
    begin
        hsh = CW'(hd_i) << K;
        ssh = CW'(sd_i) << K;
        hn_next = hn_i;
        hq_next = hq_i;
        sn_next = sn_i;
        sq_next = sq_i;
        if (CW'(hn_i) >= hsh)
        begin
            hn_next = hn_i - hsh[NW-1:0];
            hq_next[K] = 1'b1;
        end
        if (CW'(sn_i) >= ssh)
        begin
            sn_next = sn_i - ssh[NW-1:0];
            sq_next[K] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_i;
        hn_reg  <= hn_next;
        sn_reg  <= sn_next;
        hd_reg  <= hd_i;
        sd_reg  <= sd_i;
        hq_reg  <= hq_next;
        sq_reg  <= sq_next;
    end

    assign valid_o = valid_reg;
    assign val_o   = val_reg;
    assign hn_o    = hn_reg;
    assign sn_o    = sn_reg;
    assign hd_o    = hd_reg;
    assign sd_o    = sd_reg;
    assign hq_o    = hq_reg;
    assign sq_o    = sq_reg;
endmodule

// ===== hdl/rgb_to_hsv_converter.sv =====
// Throughput: one transaction per cycle; busy is always low.
// One divider cell per quotient bit sets the latency.
// Reset clears the valid chain; no result is produced until a new start.
// The receiver cannot stall: done is a single-cycle strobe.
// Top level of the RGB to HSV converter; depends on rgbhsv_pkg, rgbhsv_prep,
// rgbhsv_cell and assert_macros.svh.
`include "assert_macros.svh"
module rgb_to_hsv_converter
    import rgbhsv_pkg::*;
#(
    parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF,
    parameter int SAT_FRAC_BITS = SAT_FRAC_BITS_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    output logic   busy,
    input  pixel_t pixel,
    output logic   done,
    output hsv_t   result
);
    localparam int HQW = 9 + HUE_FRAC_BITS;
    localparam int SQW = SAT_FRAC_BITS + 1;
    localparam int QW  = (HQW > SQW) ? HQW : SQW;
    localparam int NWH = 18 + HUE_FRAC_BITS;
    localparam int NWS = 10 + SAT_FRAC_BITS;
    localparam int NW  = (NWH > NWS) ? NWH : NWS;
    localparam logic [QW-1:0] FULL_TURN = QW'(360) << HUE_FRAC_BITS;

    logic          v_c   [0:QW];
    logic [7:0]    val_c [0:QW];
    logic [NW-1:0] hn_c  [0:QW];
    logic [7:0]    hd_c  [0:QW];
    logic [NW-1:0] sn_c  [0:QW];
    logic [7:0]    sd_c  [0:QW];
    logic [QW-1:0] hq_c  [0:QW];
    logic [QW-1:0] sq_c  [0:QW];

    logic done_reg;
    hsv_t result_reg, result_next;

    rgbhsv_prep #(.HF(HUE_FRAC_BITS), .SF(SAT_FRAC_BITS), .NW(NW)) u_prep (
        .clk(clk), .rst_n(rst_n), .start(start), .pixel(pixel),
        .valid(v_c[0]), .val(val_c[0]), .hn(hn_c[0]), .hd(hd_c[0]),
        .sn(sn_c[0]), .sd(sd_c[0])
    );

    assign hq_c[0] = '0;
    assign sq_c[0] = '0;

    for (genvar i = 0; i < QW; i++)
    begin : g_cell
        rgbhsv_cell #(.NW(NW), .QW(QW), .K(QW - 1 - i)) u_cell (
            .clk(clk), .rst_n(rst_n),
            .valid_i(v_c[i]), .val_i(val_c[i]), .hn_i(hn_c[i]), .hd_i(hd_c[i]),
            .sn_i(sn_c[i]), .sd_i(sd_c[i]), .hq_i(hq_c[i]), .sq_i(sq_c[i]),
            .valid_o(v_c[i+1]), .val_o(val_c[i+1]), .hn_o(hn_c[i+1]),
            .hd_o(hd_c[i+1]), .sn_o(sn_c[i+1]), .sd_o(sd_c[i+1]),
            .hq_o(hq_c[i+1]), .sq_o(sq_c[i+1])
        );
    end

    always_comb
    begin
        result_next.hue        = (hq_c[QW] >= FULL_TURN) ? 15'd0 : 15'(hq_c[QW]);
        result_next.saturation = 16'(sq_c[QW]);
        result_next.brightness = val_c[QW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= v_c[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    `ASSERT_IMPL(a_black_hue, done && (result.brightness == 8'd0), result.hue == 15'd0)
    `ASSERT_IMPL(a_black_sat, done && (result.brightness == 8'd0), result.saturation == 16'd0)
    `ASSERT_NEVER(a_hue_range, v_c[QW] && (hq_c[QW] > FULL_TURN))
endmodule
